// File: design/ttwp_pkg.sv
// Package for the text tokenizer: scan modes, token kinds, byte codes.
// No dependencies.
`timescale 1ns / 1ps
package ttwp_pkg;
  localparam int OFFSET_BITS_DEF = 24;
  localparam int LINE_BITS_DEF = 20;
  localparam int COLUMN_BITS_DEF = 16;
  localparam logic [4:0] TAB_SIZE_RST = 5'd4;

  typedef enum logic [7:0] {
    M_IDLE      = 8'b0000_0001,
    M_WORD      = 8'b0000_0010,
    M_SLASH     = 8'b0000_0100,
    M_LINECMT   = 8'b0000_1000,
    M_BLOCK     = 8'b0001_0000,
    M_BLOCKSTAR = 8'b0010_0000,
    M_QUOTE     = 8'b0100_0000,
    M_QUOTEESC  = 8'b1000_0000
  } mode_t;

  typedef enum logic [1:0] {BRK_NONE = 2'd0, BRK_CR = 2'd1, BRK_LF = 2'd2} brk_t;

  localparam logic [3:0] K_OPEN_DICT  = 4'd0;
  localparam logic [3:0] K_CLOSE_DICT = 4'd1;
  localparam logic [3:0] K_OPEN_LIST  = 4'd2;
  localparam logic [3:0] K_CLOSE_LIST = 4'd3;
  localparam logic [3:0] K_COLON      = 4'd4;
  localparam logic [3:0] K_ANNOTATE   = 4'd5;
  localparam logic [3:0] K_COMMENT    = 4'd6;
  localparam logic [3:0] K_WORD       = 4'd7;
  localparam logic [3:0] K_END        = 4'd8;

  localparam logic [7:0] C_NUL = 8'h00;
  localparam logic [7:0] C_TAB = 8'h09;
  localparam logic [7:0] C_LF = 8'h0A;
  localparam logic [7:0] C_CR = 8'h0D;
  localparam logic [7:0] C_SP = 8'h20;
  localparam logic [7:0] C_DQ = 8'h22;
  localparam logic [7:0] C_HASH = 8'h23;
  localparam logic [7:0] C_SQ = 8'h27;
  localparam logic [7:0] C_STAR = 8'h2A;
  localparam logic [7:0] C_COMMA = 8'h2C;
  localparam logic [7:0] C_SLASH = 8'h2F;
  localparam logic [7:0] C_COLON = 8'h3A;
  localparam logic [7:0] C_AT = 8'h40;
  localparam logic [7:0] C_LBRK = 8'h5B;
  localparam logic [7:0] C_BSL = 8'h5C;
  localparam logic [7:0] C_RBRK = 8'h5D;
  localparam logic [7:0] C_LBRC = 8'h7B;
  localparam logic [7:0] C_RBRC = 8'h7D;
endpackage

// File: design/text_tokenizer_with_positions_unit.sv
// Latency: an item's tokens appear in the output register the cycle after it is taken.
// Throughput: one byte per cycle while out_stall is low; a byte that yields two tokens
// holds the input while the second token drains from the two-entry output queue.
// Reset (rst_n, synchronous): scan state, positions and queue cleared, tab_size back to 4.
// Tokenizer top level: scan state machine, position tracking, token output queue.
// Depends on ttwp_pkg.
`timescale 1ns / 1ps
module text_tokenizer_with_positions_unit #(
  parameter int OFFSET_BITS = ttwp_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS = ttwp_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = ttwp_pkg::COLUMN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_tab_size,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic [23:0] out_start_offset,
  output logic [23:0] out_token_length,
  output logic [19:0] out_start_line,
  output logic [15:0] out_start_column,
  output logic        out_is_end
);
  typedef struct packed {
    logic [3:0]             kind;
    logic [OFFSET_BITS-1:0] off;
    logic [OFFSET_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic                   is_end;
  } tok_t;

  localparam logic [OFFSET_BITS-1:0] OMAX = '1;
  localparam logic [LINE_BITS-1:0] LMAX = '1;
  localparam logic [COLUMN_BITS-1:0] CMAX = '1;

  logic [4:0] tab_size_r;
  ttwp_pkg::mode_t mode_r, mode_nxt;
  logic qdbl_r, qdbl_nxt;
  ttwp_pkg::brk_t brk_r, brk_nxt;
  logic [OFFSET_BITS-1:0] boff_r, boff_nxt, toff_r, toff_nxt, tcnt_r, tcnt_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt, tline_r, tline_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt, tcol_r, tcol_nxt;
  logic [3:0] phase_r, phase_nxt;

  tok_t q_r [2];
  logic [1:0] cnt_r;
  tok_t t0, t1;
  logic n_tok0, n_tok1;
  logic acc, pop;

  // queue: slot 0 is the head
  assign in_stall = (cnt_r == 2'd2) || (cnt_r == 2'd1 && out_stall);
  assign acc = in_valid && !in_stall;
  assign out_valid = cnt_r != 2'd0;
  assign pop = out_valid && !out_stall;

  logic [4:0] ts;
  always_comb begin
    ts = tab_size_r;
    if (ts == 5'd0) ts = 5'd1;
    if (ts > 5'd16) ts = 5'd16;
  end

  // position advance for byte b from current state
  logic [LINE_BITS-1:0] a_line;
  logic [COLUMN_BITS-1:0] a_col;
  logic [3:0] a_phase;
  ttwp_pkg::brk_t a_brk;
  logic [OFFSET_BITS-1:0] a_off;
  logic [4:0] adv, ph1;
  logic [COLUMN_BITS:0] csum;
  logic [7:0] b;
  assign b = in_text_byte;

  always_comb begin
    a_line = line_r;
    a_col = col_r;
    a_phase = phase_r;
    a_brk = ttwp_pkg::BRK_NONE;
    adv = ({1'b0, phase_r} < ts) ? ts - {1'b0, phase_r} : ts;
    ph1 = {1'b0, phase_r} + 5'd1;
    csum = '0;
    a_off = (boff_r == OMAX) ? OMAX : boff_r + 1'b1;
    if (b == ttwp_pkg::C_CR || b == ttwp_pkg::C_LF) begin
      if ((b == ttwp_pkg::C_CR && brk_r == ttwp_pkg::BRK_LF) ||
          (b == ttwp_pkg::C_LF && brk_r == ttwp_pkg::BRK_CR)) begin
        a_brk = ttwp_pkg::BRK_NONE;
      end else begin
        a_line = (line_r == LMAX) ? LMAX : line_r + 1'b1;
        a_col = '0;
        a_phase = '0;
        a_brk = (b == ttwp_pkg::C_CR) ? ttwp_pkg::BRK_CR : ttwp_pkg::BRK_LF;
      end
    end else if (b == ttwp_pkg::C_TAB) begin
      csum = {1'b0, col_r} + {{(COLUMN_BITS-4){1'b0}}, adv};
      a_col = csum[COLUMN_BITS] ? CMAX : csum[COLUMN_BITS-1:0];
      a_phase = '0;
    end else begin
      a_col = (col_r == CMAX) ? CMAX : col_r + 1'b1;
      a_phase = (ph1 >= ts) ? 4'd0 : ph1[3:0];
    end
  end

  logic ends_word, is_punct;
  logic [3:0] pkind;
  always_comb begin
    is_punct = 1'b1;
    pkind = ttwp_pkg::K_OPEN_DICT;
    unique case (b)
      ttwp_pkg::C_LBRC:  pkind = ttwp_pkg::K_OPEN_DICT;
      ttwp_pkg::C_RBRC:  pkind = ttwp_pkg::K_CLOSE_DICT;
      ttwp_pkg::C_LBRK:  pkind = ttwp_pkg::K_OPEN_LIST;
      ttwp_pkg::C_RBRK:  pkind = ttwp_pkg::K_CLOSE_LIST;
      ttwp_pkg::C_COLON: pkind = ttwp_pkg::K_COLON;
      ttwp_pkg::C_AT:    pkind = ttwp_pkg::K_ANNOTATE;
      default:           is_punct = 1'b0;
    endcase
    ends_word = is_punct || b == ttwp_pkg::C_NUL || b == ttwp_pkg::C_SP ||
                b == ttwp_pkg::C_TAB || b == ttwp_pkg::C_COMMA || b == ttwp_pkg::C_CR ||
                b == ttwp_pkg::C_LF || b == ttwp_pkg::C_HASH;
  end

  logic [OFFSET_BITS-1:0] cnt_inc;
  assign cnt_inc = (tcnt_r == OMAX) ? OMAX : tcnt_r + 1'b1;

  tok_t open_tok;
  ttwp_pkg::mode_t eff;

  always_comb begin
    mode_nxt = mode_r; qdbl_nxt = qdbl_r; brk_nxt = brk_r;
    boff_nxt = boff_r; line_nxt = line_r; col_nxt = col_r; phase_nxt = phase_r;
    toff_nxt = toff_r; tline_nxt = tline_r; tcol_nxt = tcol_r; tcnt_nxt = tcnt_r;
    t0 = '0; t1 = '0; n_tok0 = 1'b0; n_tok1 = 1'b0;
    open_tok = '{kind: ttwp_pkg::K_WORD, off: toff_r, len: tcnt_r, line: tline_r,
                 col: tcol_r, is_end: 1'b0};
    eff = mode_r;
    if (mode_r == ttwp_pkg::M_SLASH && b != ttwp_pkg::C_SLASH && b != ttwp_pkg::C_STAR)
      eff = ttwp_pkg::M_WORD;
    // default: byte consumed into token
    begin
      logic go_idle;
      go_idle = 1'b0;
      unique case (eff)
        ttwp_pkg::M_SLASH: begin
          mode_nxt = (b == ttwp_pkg::C_SLASH) ? ttwp_pkg::M_LINECMT : ttwp_pkg::M_BLOCK;
        end
        ttwp_pkg::M_WORD: begin
          mode_nxt = ttwp_pkg::M_WORD;
          if (ends_word) begin
            go_idle = 1'b1; n_tok0 = 1'b1; t0 = open_tok;
          end
        end
        ttwp_pkg::M_LINECMT: begin
          if (b == ttwp_pkg::C_NUL || b == ttwp_pkg::C_CR || b == ttwp_pkg::C_LF) begin
            go_idle = 1'b1; n_tok0 = 1'b1; t0 = open_tok; t0.kind = ttwp_pkg::K_COMMENT;
          end
        end
        ttwp_pkg::M_BLOCK, ttwp_pkg::M_BLOCKSTAR: begin
          if (b == ttwp_pkg::C_NUL) begin
            go_idle = 1'b1; n_tok0 = 1'b1; t0 = open_tok; t0.kind = ttwp_pkg::K_COMMENT;
          end else if (eff == ttwp_pkg::M_BLOCKSTAR && b == ttwp_pkg::C_SLASH) begin
            n_tok0 = 1'b1; t0 = open_tok; t0.kind = ttwp_pkg::K_COMMENT;
            t0.len = cnt_inc; mode_nxt = ttwp_pkg::M_IDLE;
          end else begin
            mode_nxt = (b == ttwp_pkg::C_STAR) ? ttwp_pkg::M_BLOCKSTAR : ttwp_pkg::M_BLOCK;
          end
        end
        ttwp_pkg::M_QUOTE, ttwp_pkg::M_QUOTEESC: begin
          if (b == ttwp_pkg::C_NUL) begin
            go_idle = 1'b1; n_tok0 = 1'b1; t0 = open_tok;
          end else if (eff == ttwp_pkg::M_QUOTEESC) begin
            mode_nxt = ttwp_pkg::M_QUOTE;
          end else if (b == (qdbl_r ? ttwp_pkg::C_DQ : ttwp_pkg::C_SQ)) begin
            n_tok0 = 1'b1; t0 = open_tok; t0.len = cnt_inc; mode_nxt = ttwp_pkg::M_IDLE;
          end else if (b == ttwp_pkg::C_BSL) begin
            mode_nxt = ttwp_pkg::M_QUOTEESC;
          end
        end
        default: go_idle = 1'b1;
      endcase
      if (!go_idle) begin
        tcnt_nxt = cnt_inc;
        brk_nxt = a_brk; boff_nxt = a_off; line_nxt = a_line; col_nxt = a_col;
        phase_nxt = a_phase;
      end else begin
        tok_t it;
        logic has;
        has = 1'b0;
        it = '{kind: pkind, off: boff_r, len: {{(OFFSET_BITS-1){1'b0}}, 1'b1},
               line: line_r, col: col_r, is_end: 1'b0};
        mode_nxt = ttwp_pkg::M_IDLE;
        if (b == ttwp_pkg::C_NUL) begin
          has = 1'b1; it.kind = ttwp_pkg::K_END; it.is_end = 1'b1;
          qdbl_nxt = 1'b0; brk_nxt = ttwp_pkg::BRK_NONE; boff_nxt = '0; line_nxt = '0;
          col_nxt = '0; phase_nxt = '0; toff_nxt = '0; tline_nxt = '0; tcol_nxt = '0;
          tcnt_nxt = '0;
        end else begin
          brk_nxt = a_brk; boff_nxt = a_off; line_nxt = a_line; col_nxt = a_col;
          phase_nxt = a_phase;
          if (is_punct) begin
            has = 1'b1;
          end else if (!(b == ttwp_pkg::C_SP || b == ttwp_pkg::C_TAB ||
                         b == ttwp_pkg::C_COMMA || b == ttwp_pkg::C_CR ||
                         b == ttwp_pkg::C_LF)) begin
            toff_nxt = boff_r; tline_nxt = line_r; tcol_nxt = col_r;
            tcnt_nxt = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
            if (b == ttwp_pkg::C_HASH) mode_nxt = ttwp_pkg::M_LINECMT;
            else if (b == ttwp_pkg::C_SLASH) mode_nxt = ttwp_pkg::M_SLASH;
            else if (b == ttwp_pkg::C_DQ || b == ttwp_pkg::C_SQ) begin
              mode_nxt = ttwp_pkg::M_QUOTE; qdbl_nxt = (b == ttwp_pkg::C_DQ);
            end else mode_nxt = ttwp_pkg::M_WORD;
          end
        end
        if (has) begin
          if (n_tok0) begin n_tok1 = 1'b1; t1 = it; end
          else begin n_tok0 = 1'b1; t0 = it; end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_size_r <= ttwp_pkg::TAB_SIZE_RST;
      mode_r <= ttwp_pkg::M_IDLE; qdbl_r <= 1'b0; brk_r <= ttwp_pkg::BRK_NONE;
      boff_r <= '0; line_r <= '0; col_r <= '0; phase_r <= '0;
      toff_r <= '0; tline_r <= '0; tcol_r <= '0; tcnt_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_we) tab_size_r <= cfg_tab_size;
      if (acc) begin
        mode_r <= mode_nxt; qdbl_r <= qdbl_nxt; brk_r <= brk_nxt;
        boff_r <= boff_nxt; line_r <= line_nxt; col_r <= col_nxt; phase_r <= phase_nxt;
        toff_r <= toff_nxt; tline_r <= tline_nxt; tcol_r <= tcol_nxt; tcnt_r <= tcnt_nxt;
      end
      cnt_r <= cnt_r - {1'b0, pop} + ((acc && n_tok0) ? (n_tok1 ? 2'd2 : 2'd1) : 2'd0);
    end
  end

  // queue data; acceptance implies cnt_r==0, or cnt_r==1 with pop
  always_ff @(posedge clk) begin
    if (pop && cnt_r == 2'd2) q_r[0] <= q_r[1];
    if (acc && n_tok0) begin
      q_r[0] <= t0;
      q_r[1] <= t1;
    end
  end

  assign out_token_kind = q_r[0].kind;
  assign out_start_offset = 24'(q_r[0].off);
  assign out_token_length = 24'(q_r[0].len);
  assign out_start_line = 20'(q_r[0].line);
  assign out_start_column = 16'(q_r[0].col);
  assign out_is_end = q_r[0].is_end;

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count overflow");
  a_acc_room: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop)))
    else $error("accept without queue room");
  a_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_text_byte == ttwp_pkg::C_NUL) |=> (boff_r == '0 && mode_r == ttwp_pkg::M_IDLE))
    else $error("end byte did not restart scan");
`endif
endmodule
